// File: hw/rtl/tar_numeric_field_encoder_unit_assert.svh
// assertion macros for the tar numeric field encoder, sampled on clk;
// TNFE_ASSERT is disabled while arst_n is low, TNFE_ASSERT_ANY is not
`ifndef TAR_NUMERIC_FIELD_ENCODER_UNIT_ASSERT_SVH
`define TAR_NUMERIC_FIELD_ENCODER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define TNFE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define TNFE_ASSERT_ANY(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TNFE_ASSERT(lbl, prop, msg)
`define TNFE_ASSERT_ANY(lbl, prop, msg)
`endif
`endif

// File: hw/rtl/tnfe_pkg.sv
`timescale 1ns / 1ps
package tnfe_pkg;

	localparam int VALUE_BITS = 64;
	localparam int MAX_FIELD_BYTES_DEF = 12;

	typedef enum logic [1:0] {
		ENC_OCTAL_SPACE = 2'd0,
		ENC_OCTAL_FULL  = 2'd1,
		ENC_BASE256     = 2'd2
	} enc_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUILD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] number_value;
		logic                  is_signed;
		logic [3:0]            field_width;
	} tnfe_in_t;

	typedef struct packed {
		logic [7:0] field_byte;
		logic       last_byte;
		logic [1:0] encoding_used;
	} tnfe_out_t;

	// control from the sequencer to the digit generator
	typedef struct packed {
		logic load;
		logic step;
		enc_t enc;
		logic neg;
		logic space_slot;
		logic mark_msb;
	} tnfe_gen_ctl_t;

	typedef struct packed {
		logic push;
		logic pop;
	} tnfe_stk_ctl_t;

endpackage

// File: hw/rtl/tnfe_stream_if.sv
`timescale 1ns / 1ps
interface tnfe_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/tar_numeric_field_encoder_unit.sv
`timescale 1ns / 1ps
// operation: a field of w bytes (2..MAX_FIELD_BYTES) is built in full after the input transfer
// and then leaves one byte per cycle while the output side is ready; a new item is taken only
// once the last byte of the previous one leaves; the digit generator builds
// the bytes rightmost first, one per cycle, and the byte stack plays them back leftmost first
// reset: arst_n clears the sequencer to idle; value and byte storage are not reset
`include "tar_numeric_field_encoder_unit_assert.svh"
module tar_numeric_field_encoder_unit import tnfe_pkg::*; #(
	parameter int MAX_FIELD_BYTES = MAX_FIELD_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	tnfe_stream_if.sink   req,
	tnfe_stream_if.source rsp
);

	// counter wide enough for the field width port and for the largest field
	localparam int CW = ($clog2(MAX_FIELD_BYTES + 1) > 4) ? $clog2(MAX_FIELD_BYTES + 1) : 4;

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] wid_q;
	enc_t          enc_q;
	logic          neg_q;

	logic [CW-1:0] wid_in;
	logic          neg_in;
	enc_t          enc_in;

	tnfe_gen_ctl_t gen_ctl;
	tnfe_stk_ctl_t stk_ctl;
	logic [7:0]    gen_byte;
	logic [7:0]    top_byte;
	logic          req_ready;
	logic          rsp_valid;

	// true when the value fits in the given number of octal digits
	function automatic logic fits_octal(input logic [VALUE_BITS-1:0] v,
			input logic [CW-1:0] digits);
		logic [7:0]            n;
		logic [VALUE_BITS-1:0] low_mask;
		n = 8'(3 * int'(digits));
		low_mask = (VALUE_BITS'(1) << n) - VALUE_BITS'(1);
		if (n >= 8'(VALUE_BITS)) begin
			return 1'b1;
		end
		return (v & ~low_mask) == '0;
	endfunction

	// saturate the requested width into 2..MAX_FIELD_BYTES
	always_comb begin
		if (CW'(req.data.field_width) < CW'(2)) begin
			wid_in = CW'(2);
		end else if (CW'(req.data.field_width) > CW'(MAX_FIELD_BYTES)) begin
			wid_in = CW'(MAX_FIELD_BYTES);
		end else begin
			wid_in = CW'(req.data.field_width);
		end
	end

	// encoding choice: negative always base-256, else the shortest octal form that fits, else base-256
	assign neg_in = req.data.is_signed & req.data.number_value[VALUE_BITS-1];

	always_comb begin
		if (neg_in) begin
			enc_in = ENC_BASE256;
		end else if (fits_octal(req.data.number_value, wid_in - CW'(1))) begin
			enc_in = ENC_OCTAL_SPACE;
		end else if (fits_octal(req.data.number_value, wid_in)) begin
			enc_in = ENC_OCTAL_FULL;
		end else begin
			enc_in = ENC_BASE256;
		end
	end

	// item attributes, captured at the input transfer
	always_ff @(posedge clk) begin
		if (req.valid && req_ready) begin
			wid_q <= wid_in;
			enc_q <= enc_in;
			neg_q <= neg_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// sequencer: build counts byte positions up from the right, emit counts bytes left down
	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		req_ready    = 1'b0;
		rsp_valid    = 1'b0;
		stk_ctl.push = 1'b0;
		stk_ctl.pop  = 1'b0;
		gen_ctl.load = 1'b0;
		gen_ctl.step = 1'b0;
		gen_ctl.enc  = enc_q;
		gen_ctl.neg  = neg_q;
		// rightmost slot of the octal-plus-space form is the space
		gen_ctl.space_slot = (enc_q == ENC_OCTAL_SPACE) && (cnt_q == '0);
		// leftmost byte carries the base-256 marker
		gen_ctl.mark_msb   = (cnt_q == wid_q - CW'(1));
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
			end
			ST_BUILD: begin
				stk_ctl.push = 1'b1;
				gen_ctl.step = 1'b1;
				if (cnt_q == wid_q - CW'(1)) begin
					state_d = ST_EMIT;
					cnt_d   = wid_q - CW'(1);
				end else begin
					cnt_d = cnt_q + CW'(1);
				end
			end
			ST_EMIT: begin
				rsp_valid = 1'b1;
				if (rsp.ready) begin
					stk_ctl.pop = 1'b1;
					if (cnt_q == '0) begin
						// last byte leaves, so a new item may come in on the same edge
						req_ready = 1'b1;
						state_d   = ST_IDLE;
					end else begin
						cnt_d = cnt_q - CW'(1);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (req.valid && req_ready) begin
			gen_ctl.load = 1'b1;
			state_d      = ST_BUILD;
			cnt_d        = '0;
		end
	end

	tnfe_digit_gen u_digit_gen (
		.clk        (clk),
		.ctl        (gen_ctl),
		.load_value (req.data.number_value),
		.gen_byte   (gen_byte)
	);

	tnfe_byte_stack #(
		.DEPTH (MAX_FIELD_BYTES)
	) u_byte_stack (
		.clk       (clk),
		.ctl       (stk_ctl),
		.push_byte (gen_byte),
		.top_byte  (top_byte)
	);

	// output transfer straight from the top of the byte stack
	assign req.ready                  = req_ready;
	assign rsp.valid                  = rsp_valid;
	assign rsp.data.field_byte        = top_byte;
	assign rsp.data.last_byte         = (cnt_q == '0);
	assign rsp.data.encoding_used     = enc_q;

	`TNFE_ASSERT(a_load_starts_build, req.valid && req.ready |=> state_q == ST_BUILD && cnt_q == '0, "input transfer did not start a build")
	`TNFE_ASSERT(a_build_in_field, state_q == ST_BUILD |-> cnt_q < wid_q, "build position beyond field width")
	`TNFE_ASSERT(a_width_range, state_q != ST_IDLE |-> wid_q >= CW'(2) && wid_q <= CW'(MAX_FIELD_BYTES), "field width out of range")
	`TNFE_ASSERT(a_last_ends_emit, rsp.valid && rsp.ready && rsp.data.last_byte |=> state_q != ST_EMIT, "emit continued past last byte")
	`TNFE_ASSERT_ANY(a_reset_idle, !arst_n |-> state_q == ST_IDLE && !rsp.valid, "not idle during reset")

endmodule

// File: hw/rtl/tnfe_digit_gen.sv
`timescale 1ns / 1ps
module tnfe_digit_gen import tnfe_pkg::*; (
	input  logic                  clk,
	input  tnfe_gen_ctl_t         ctl,
	input  logic [VALUE_BITS-1:0] load_value,
	output logic [7:0]            gen_byte
);

	logic [VALUE_BITS-1:0] val_q;

	// value walks right one octal digit or one byte per step, but holds at the space slot
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			val_q <= load_value;
		end else if (ctl.step && !ctl.space_slot) begin
			if (ctl.enc == ENC_BASE256) begin
				val_q <= {{8{ctl.neg}}, val_q[VALUE_BITS-1:8]};
			end else begin
				val_q <= {3'b000, val_q[VALUE_BITS-1:3]};
			end
		end
	end

	always_comb begin
		case (ctl.enc)
			ENC_OCTAL_SPACE: begin
				gen_byte = ctl.space_slot ? 8'h20 : {5'b00110, val_q[2:0]};
			end
			ENC_OCTAL_FULL: begin
				gen_byte = {5'b00110, val_q[2:0]};
			end
			ENC_BASE256: begin
				gen_byte = {val_q[7] | ctl.mark_msb, val_q[6:0]};
			end
			default: begin
				gen_byte = 8'h00;
			end
		endcase
	end

endmodule

// File: hw/rtl/tnfe_byte_stack.sv
`timescale 1ns / 1ps
module tnfe_byte_stack import tnfe_pkg::*; #(
	parameter int DEPTH = MAX_FIELD_BYTES_DEF
) (
	input  logic          clk,
	input  tnfe_stk_ctl_t ctl,
	input  logic [7:0]    push_byte,
	output logic [7:0]    top_byte
);

	logic [7:0] stk_q [DEPTH];

	// push shifts toward the deep end, pop shifts back toward the top
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			stk_q[0] <= push_byte;
			for (int k = 1; k < DEPTH; k++) begin
				stk_q[k] <= stk_q[k-1];
			end
		end else if (ctl.pop) begin
			for (int k = 0; k < DEPTH - 1; k++) begin
				stk_q[k] <= stk_q[k+1];
			end
			stk_q[DEPTH-1] <= 8'h00;
		end
	end

	assign top_byte = stk_q[0];

endmodule

// File: tb/tb_tar_numeric_field_encoder_unit.sv
`timescale 1ns / 1ps
module tb_tar_numeric_field_encoder_unit;
	import tnfe_pkg::*;

	localparam int FIELD_MAX     = MAX_FIELD_BYTES_DEF;
	localparam int RANDOM_FIELDS = 410;
	localparam int TAIL_CYCLES   = 2 * FIELD_MAX + 6;

	// characters and marks of the tar numeric formats
	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_SPACE = 8'h20;
	localparam logic [7:0] B256_MARK   = 8'h80;
	localparam logic [7:0] SIGN_FILL   = 8'hFF;

	// works out the byte string of every accepted field and holds it until the
	// output side hands the bytes back, oldest first
	class field_byte_scoreboard;
		tnfe_out_t   pending_bytes[$];
		int unsigned errors;
		int unsigned fields_seen;
		int unsigned bytes_checked;
		int unsigned enc_count[3];

		function logic [7:0] octal_digit(logic [63:0] v, int pos);
			if (3 * pos >= 64)
				return ASCII_ZERO;
			return ASCII_ZERO + 8'((v >> (3 * pos)) & 64'd7);
		endfunction

		function logic [7:0] binary_digit(logic [63:0] v, logic neg, int pos);
			if (pos >= 8)
				return neg ? SIGN_FILL : 8'h00;
			return 8'((v >> (8 * pos)) & 64'hFF);
		endfunction

		function void note_input(tnfe_in_t item);
			logic [63:0] v;
			logic        neg;
			int          w;
			int          right;
			enc_t        enc;
			tnfe_out_t   b;

			v   = item.number_value;
			neg = item.is_signed && v[63];
			w   = int'(item.field_width);
			if (w < 2)
				w = 2;
			if (w > FIELD_MAX)
				w = FIELD_MAX;

			if (neg)
				enc = ENC_BASE256;
			else if (3 * (w - 1) >= 64 || (v >> (3 * (w - 1))) == 64'd0)
				enc = ENC_OCTAL_SPACE;
			else if (3 * w >= 64 || (v >> (3 * w)) == 64'd0)
				enc = ENC_OCTAL_FULL;
			else
				enc = ENC_BASE256;

			for (int i = 0; i < w; i++) begin
				right = w - 1 - i;
				case (enc)
					ENC_OCTAL_SPACE: begin
						b.field_byte = (right == 0) ? ASCII_SPACE : octal_digit(v, right - 1);
					end
					ENC_OCTAL_FULL: begin
						b.field_byte = octal_digit(v, right);
					end
					default: begin
						b.field_byte = binary_digit(v, neg, right);
						if (i == 0)
							b.field_byte |= B256_MARK;
					end
				endcase
				b.last_byte     = (i == w - 1);
				b.encoding_used = enc;
				pending_bytes.push_back(b);
			end
			fields_seen++;
			enc_count[int'(enc)]++;
		endfunction

		function void check_result(tnfe_out_t got);
			tnfe_out_t want;

			if (pending_bytes.size() == 0) begin
				errors++;
				$display("%0t: byte %h last %b enc %0d with nothing outstanding",
					$time, got.field_byte, got.last_byte, got.encoding_used);
				return;
			end
			want = pending_bytes.pop_front();
			bytes_checked++;
			if (got.field_byte !== want.field_byte) begin
				errors++;
				$display("%0t: field_byte expected %h actual %h",
					$time, want.field_byte, got.field_byte);
			end
			if (got.last_byte !== want.last_byte) begin
				errors++;
				$display("%0t: last_byte expected %b actual %b",
					$time, want.last_byte, got.last_byte);
			end
			if (got.encoding_used !== want.encoding_used) begin
				errors++;
				$display("%0t: encoding_used expected %0d actual %0d",
					$time, want.encoding_used, got.encoding_used);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	// when set, neither side idles, so back-to-back transfers get exercised
	bit   calm_phase;

	field_byte_scoreboard sb = new();

	tnfe_stream_if #(.T(tnfe_in_t))  req_if ();
	tnfe_stream_if #(.T(tnfe_out_t)) rsp_if ();

	tar_numeric_field_encoder_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// idle length: mostly none or short, now and then a long one
	function automatic int pick_gap();
		int r;

		r = $urandom_range(0, 99);
		if (calm_phase || r < 60)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic tnfe_in_t make_field(logic [63:0] v, logic s, logic [3:0] w);
		tnfe_in_t item;

		item.number_value = v;
		item.is_signed    = s;
		item.field_width  = w;
		return item;
	endfunction

	// random field biased toward the octal digit boundaries of its width
	function automatic tnfe_in_t random_field();
		logic [63:0] v;
		logic [3:0]  wf;
		int          w;
		int          len;

		// a few widths outside 2..12 to hit the saturation
		if ($urandom_range(0, 19) == 0)
			wf = 4'($urandom_range(0, 15));
		else
			wf = 4'($urandom_range(2, FIELD_MAX));
		w = (wf < 2) ? 2 : ((wf > FIELD_MAX) ? FIELD_MAX : int'(wf));

		case ($urandom_range(0, 7))
			0: v = {$urandom, $urandom};
			1: begin
				len = $urandom_range(1, 64);
				v   = {$urandom, $urandom} >> (64 - len);
			end
			// around the limit of width-1 digits
			2: v = (64'd1 << (3 * (w - 1))) + 64'($urandom_range(0, 2)) - 64'd1;
			// around the limit of width digits
			3: v = (64'd1 << (3 * w)) + 64'($urandom_range(0, 2)) - 64'd1;
			4: v = 64'($urandom_range(0, 7));
			5: v = {$urandom, $urandom} | (64'd1 << 63);
			6: v = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
			default: v = 64'($urandom_range(0, 4095));
		endcase
		return make_field(v, 1'($urandom_range(0, 1)), wf);
	endfunction

	// holds valid for one field until it is taken; a gap first drops valid
	task automatic send_field(input tnfe_in_t item, input int gap);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data  <= item;
		do @(posedge clk); while (!req_if.ready);
		sb.note_input(item);
	endtask

	// sender stands still until every outstanding byte has come back
	task automatic drain_results();
		req_if.valid <= 1'b0;
		while (sb.pending_bytes.size() != 0)
			@(posedge clk);
	endtask

	// output side: checks each transfer and stalls ready at random
	initial begin
		int stall;

		rsp_if.ready = 1'b0;
		stall = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_if.valid && rsp_if.ready)
				sb.check_result(rsp_if.data);
			if (stall > 0) begin
				rsp_if.ready <= 1'b0;
				stall--;
			end else begin
				rsp_if.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall = pick_gap();
			end
		end
	end

	initial begin
		tnfe_in_t directed[$];

		arst_n       = 1'b0;
		calm_phase   = 1'b0;
		req_if.valid = 1'b0;
		req_if.data  = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// narrowest field: octal with space, full octal, just past into base-256
		directed.push_back(make_field(64'd0, 1'b0, 4'd2));
		directed.push_back(make_field(64'd7, 1'b0, 4'd2));
		directed.push_back(make_field(64'd8, 1'b0, 4'd2));
		directed.push_back(make_field(64'd63, 1'b0, 4'd2));
		directed.push_back(make_field(64'd64, 1'b0, 4'd2));
		// widest field at both octal limits
		directed.push_back(make_field(64'd0, 1'b0, 4'd12));
		directed.push_back(make_field((64'd1 << 33) - 1, 1'b0, 4'd12));
		directed.push_back(make_field(64'd1 << 33, 1'b0, 4'd12));
		directed.push_back(make_field((64'd1 << 36) - 1, 1'b0, 4'd12));
		directed.push_back(make_field(64'd1 << 36, 1'b0, 4'd12));
		// all ones: zero fill when unsigned, 0xff fill when negative
		directed.push_back(make_field('1, 1'b0, 4'd12));
		directed.push_back(make_field('1, 1'b1, 4'd12));
		directed.push_back(make_field('1, 1'b1, 4'd2));
		// most negative value, signed in eight bytes and unsigned in nine
		directed.push_back(make_field(64'h8000_0000_0000_0000, 1'b1, 4'd8));
		directed.push_back(make_field(64'h8000_0000_0000_0000, 1'b0, 4'd9));
		// wide value in base-256, truncated to a short field and whole in the widest
		directed.push_back(make_field(64'h0123_4567_89AB_CDEF, 1'b0, 4'd3));
		directed.push_back(make_field(64'h0123_4567_89AB_CDEF, 1'b0, 4'd12));
		// signed but non-negative behaves as unsigned
		directed.push_back(make_field(64'd511, 1'b1, 4'd7));
		directed.push_back(make_field(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 4'd11));
		// widths outside the legal range saturate
		directed.push_back(make_field(64'd5, 1'b0, 4'd0));
		directed.push_back(make_field(64'd9, 1'b0, 4'd1));
		directed.push_back(make_field(64'd12345, 1'b0, 4'd13));
		directed.push_back(make_field('1, 1'b1, 4'd15));

		foreach (directed[i])
			send_field(directed[i], pick_gap());
		drain_results();

		// random part: every fourth block of 60 fields runs with no idling
		for (int n = 0; n < RANDOM_FIELDS; n++) begin
			calm_phase = ((n / 60) % 4 == 3);
			if (n % 100 == 50)
				drain_results();
			send_field(random_field(), pick_gap());
		end
		req_if.valid <= 1'b0;
		calm_phase = 1'b0;

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d fields, %0d bytes checked: %0d octal with space, %0d full octal, %0d base-256",
			sb.fields_seen, sb.bytes_checked, sb.enc_count[0], sb.enc_count[1], sb.enc_count[2]);
		$display("widths 0..15 with saturation, signed and unsigned values, random idling both sides");
		if (sb.errors == 0 && sb.pending_bytes.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end
endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/tnfe_pkg.sv
hw/rtl/tnfe_stream_if.sv
hw/rtl/tnfe_digit_gen.sv
hw/rtl/tnfe_byte_stack.sv
hw/rtl/tar_numeric_field_encoder_unit.sv
tb/tb_tar_numeric_field_encoder_unit.sv
